@@ design/extended_bf_interpreter_core_macros.svh @@
// Assertion macros shared by the interpreter core.
// Defining ASSERT_OFF turns every use into empty text.
`ifndef EXTENDED_BF_INTERPRETER_CORE_MACROS_SVH
`define EXTENDED_BF_INTERPRETER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// The condition post must hold in the same cycle as pre.
`define EBF_ASSERT_IMPL(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("assertion failed");

// The condition post must hold in the cycle after pre.
`define EBF_ASSERT_NEXT(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define EBF_ASSERT_IMPL(name, clock, reset, pre, post)
`define EBF_ASSERT_NEXT(name, clock, reset, pre, post)

`endif

`endif

@@ design/ebf_pkg.sv @@
package ebf_pkg;

  localparam int PC_W      = 13;
  localparam int CFG_IDX_W = 2;

  // Request kinds.
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_EXEC    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TAPE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH    = 2'd1;

  localparam logic [PC_W-1:0] INIT_TAPE_SIZE_RESET = 13'd256;
  localparam logic [PC_W-1:0] PROG_LENGTH_RESET    = 13'd0;

  // Instruction characters.
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_HASH     = 8'h23;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] address;
    logic [7:0]  code_byte;
    logic [7:0]  input_byte;
  } request_t;

  typedef struct packed {
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            halted;
    logic            error;
    logic [PC_W-1:0] program_counter;
  } result_t;

  // Classes of a program character that the bracket and comment scans need.
  typedef struct packed {
    logic is_open;
    logic is_close;
    logic is_hash;
  } prog_class_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic       clear;
  } tape_cmd_t;

  typedef struct packed {
    logic clearing;
    logic clear_last;
  } tape_status_t;

endpackage

@@ design/extended_bf_interpreter_core.sv @@
// Flow: a load, a status request or a simple instruction is taken in IDLE and executed in
// EXEC, which registers its result with done; a bracket or comment scan first walks the
// program in SCAN to its match or an end of the program, and a restart first sweeps the tape
// cells in use before it in CLEAR. A new request is taken only once busy is low in IDLE.
// Reset: synchronous; afterwards all TAPE_DEPTH tape cells are swept to zero with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
`include "extended_bf_interpreter_core_macros.svh"

module extended_bf_interpreter_core #(
  parameter int TAPE_DEPTH = 4096,
  parameter int PROG_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ebf_pkg::request_t              request,
  output logic                           done,
  output ebf_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ebf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebf_pkg::PC_W-1:0]       cfg_data
);

  // Index widths of the two memories, and the width of a tape size, which can
  // reach TAPE_DEPTH itself.
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int TSW = $clog2(TAPE_DEPTH + 1);
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int PW  = ebf_pkg::PC_W;

  // Tape size after reset: the reset value of the register, clamped to the tape.
  localparam logic [TSW-1:0] RESET_TAPE_SIZE =
    (int'(ebf_pkg::INIT_TAPE_SIZE_RESET) > TAPE_DEPTH) ? TSW'(TAPE_DEPTH)
                                                       : TSW'(ebf_pkg::INIT_TAPE_SIZE_RESET);

  // The controller. IDLE waits for a request while the memories already read
  // the instruction at the program counter and the cell at the pointer, so an
  // instruction is decoded and executed in EXEC with a single read-modify-write
  // of the tape. SCAN walks the program store one character a cycle for the
  // bracket and comment instructions. CLEAR waits on the tape sweep.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    SCAN_FWD_BRACKET,
    SCAN_FWD_COMMENT,
    SCAN_BACK_BRACKET
  } scan_mode_t;

  state_t     state, state_next;
  scan_mode_t scan_mode, scan_mode_next;

  // Architectural registers.
  logic [PW-1:0]  pc, pc_next;
  logic [TAW-1:0] cp, cp_next;
  logic [TSW-1:0] tsize, tsize_next;
  logic           err, err_next;

  // Configuration registers.
  logic [PW-1:0] init_size_cfg;
  logic [PW-1:0] prog_len_cfg;

  // Scan position and bracket depth.
  logic [PW-1:0] j, j_next;
  logic [PW-1:0] depth, depth_next;
  logic          clear_reply, clear_reply_next;

  ebf_pkg::request_t req;
  ebf_pkg::result_t  result_next;
  logic              done_next;

  // Decode and arithmetic helpers.
  logic [PW-1:0]  len;
  logic [TSW-1:0] init_clamped;
  logic [31:0]    init_w;
  logic [PW:0]    next_w;
  logic           emit;
  logic [31:0]    grow_w;
  logic [PW-1:0]  depth_new;
  logic           accept;

  // Memory ports.
  logic                  prog_we;
  logic [31:0]           prog_raddr_w;
  logic [7:0]            ins;
  ebf_pkg::prog_class_t  ins_class;
  ebf_pkg::tape_cmd_t    tape_cmd;
  ebf_pkg::tape_status_t tape_status;
  logic [7:0]            cell_q;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Execution ends at the program length, clamped to the store depth.
  assign len = (32'(prog_len_cfg) > 32'(PROG_DEPTH)) ? PW'(PROG_DEPTH) : prog_len_cfg;

  // Tape size for a restart, clamped to the range one to TAPE_DEPTH.
  always_comb begin
    init_w = 32'(init_size_cfg);
    if (init_w < 32'd1) begin
      init_clamped = TSW'(1);
    end else if (init_w > 32'(TAPE_DEPTH)) begin
      init_clamped = TSW'(TAPE_DEPTH);
    end else begin
      init_clamped = TSW'(init_w);
    end
  end

  // In IDLE and CLEAR the store reads at the program counter; during EXEC and
  // SCAN it reads ahead at the next scan position, so the scan takes one
  // character each cycle.
  assign prog_raddr_w = ((state == ST_EXEC) || (state == ST_SCAN)) ? 32'(j_next) : 32'(pc);

  ebf_prog_store #(
    .DEPTH(PROG_DEPTH),
    .AW   (PAW)
  ) u_prog (
    .clk     (clk),
    .wr_en   (prog_we),
    .wr_addr (req.address),
    .wr_data (req.code_byte),
    .rd_addr (prog_raddr_w[PAW-1:0]),
    .rd_data (ins),
    .rd_class(ins_class)
  );

  // Cells at or beyond the tape size are never written, so they stay zero
  // from the last sweep. Growth therefore needs no zeroing, and a restart
  // only sweeps the cells below the old tape size.
  ebf_tape #(
    .DEPTH(TAPE_DEPTH),
    .AW   (TAW),
    .SW   (TSW)
  ) u_tape (
    .clk        (clk),
    .rst        (rst),
    .cmd        (tape_cmd),
    .wr_addr    (cp),
    .rd_addr    (cp),
    .clear_limit(tsize),
    .rd_data    (cell_q),
    .status     (tape_status)
  );

  always_comb begin
    state_next       = state;
    scan_mode_next   = scan_mode;
    pc_next          = pc;
    cp_next          = cp;
    tsize_next       = tsize;
    err_next         = err;
    j_next           = j;
    depth_next       = depth;
    clear_reply_next = clear_reply;
    done_next        = 1'b0;
    prog_we          = 1'b0;
    tape_cmd.wr_en   = 1'b0;
    tape_cmd.wr_data = cell_q;
    tape_cmd.clear   = 1'b0;
    emit             = 1'b0;
    next_w           = {1'b0, pc} + (PW + 1)'(1);
    grow_w           = 32'(tsize) + 32'(cell_q);
    depth_new        = depth;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        case (req.kind)
          ebf_pkg::KIND_LOAD: begin
            prog_we = 1'b1;
          end

          ebf_pkg::KIND_EXEC: begin
            if (!err && (pc < len)) begin
              case (ins)
                ebf_pkg::CH_PLUS: begin
                  tape_cmd.wr_en   = 1'b1;
                  tape_cmd.wr_data = cell_q + 8'd1;
                end
                ebf_pkg::CH_MINUS: begin
                  tape_cmd.wr_en   = 1'b1;
                  tape_cmd.wr_data = cell_q - 8'd1;
                end
                ebf_pkg::CH_COMMA: begin
                  tape_cmd.wr_en   = 1'b1;
                  tape_cmd.wr_data = cell_q + req.input_byte;
                end
                ebf_pkg::CH_GT: begin
                  // A pointer move off the tape flags an error and leaves the
                  // pointer and the program counter where they were.
                  if ((32'(cp) + 32'd1) >= 32'(tsize)) begin
                    err_next = 1'b1;
                    next_w   = {1'b0, pc};
                  end else begin
                    cp_next = cp + 1'b1;
                  end
                end
                ebf_pkg::CH_LT: begin
                  if (cp == '0) begin
                    err_next = 1'b1;
                    next_w   = {1'b0, pc};
                  end else begin
                    cp_next = cp - 1'b1;
                  end
                end
                ebf_pkg::CH_LBRACKET: begin
                  if (cell_q == 8'd0) begin
                    state_next     = ST_SCAN;
                    done_next      = 1'b0;
                    scan_mode_next = SCAN_FWD_BRACKET;
                    j_next         = pc + 1'b1;
                    depth_next     = PW'(1);
                  end
                end
                ebf_pkg::CH_RBRACKET: begin
                  // At position zero there is nothing to walk: the loop
                  // restarts right after it.
                  if ((cell_q != 8'd0) && (pc != '0)) begin
                    state_next     = ST_SCAN;
                    done_next      = 1'b0;
                    scan_mode_next = SCAN_BACK_BRACKET;
                    j_next         = pc - 1'b1;
                    depth_next     = PW'(1);
                  end
                end
                ebf_pkg::CH_HASH: begin
                  state_next     = ST_SCAN;
                  done_next      = 1'b0;
                  scan_mode_next = SCAN_FWD_COMMENT;
                  j_next         = pc + 1'b1;
                end
                ebf_pkg::CH_DOT: begin
                  emit = 1'b1;
                end
                ebf_pkg::CH_RBRACE: begin
                  next_w = {1'b0, pc} + (PW + 1)'(cell_q) + (PW + 1)'(1);
                end
                ebf_pkg::CH_LBRACE: begin
                  if (PW'(cell_q) > pc) begin
                    next_w = {1'b0, len};
                  end else begin
                    next_w = {1'b0, pc} - (PW + 1)'(cell_q) + (PW + 1)'(1);
                  end
                end
                ebf_pkg::CH_EQUAL: begin
                  // Growth beyond the tape flags an error and changes nothing else.
                  if (grow_w > 32'(TAPE_DEPTH)) begin
                    err_next = 1'b1;
                    next_w   = {1'b0, pc};
                  end else begin
                    tsize_next = TSW'(grow_w);
                  end
                end
                default: begin
                end
              endcase
              if (state_next != ST_SCAN) begin
                pc_next = (next_w > {1'b0, len}) ? len : next_w[PW-1:0];
              end
            end
          end

          ebf_pkg::KIND_RESTART: begin
            // The sweep covers the cells below the old tape size, which the
            // tape latches at this edge.
            pc_next          = '0;
            cp_next          = '0;
            err_next         = 1'b0;
            tsize_next       = init_clamped;
            tape_cmd.clear   = 1'b1;
            clear_reply_next = 1'b1;
            state_next       = ST_CLEAR;
            done_next        = 1'b0;
          end

          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        case (scan_mode)
          SCAN_BACK_BRACKET: begin
            if (ins_class.is_close) begin
              depth_new = depth + 1'b1;
            end else if (ins_class.is_open) begin
              depth_new = depth - 1'b1;
            end
            depth_next = depth_new;
            if ((depth_new == '0) || (j == '0)) begin
              // Either the matching bracket or the start of the program:
              // resume right after it.
              next_w     = {1'b0, j} + (PW + 1)'(1);
              pc_next    = (next_w > {1'b0, len}) ? len : next_w[PW-1:0];
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end else begin
              j_next = j - 1'b1;
            end
          end

          SCAN_FWD_COMMENT: begin
            if (j >= len) begin
              pc_next    = len;
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end else if (ins_class.is_hash) begin
              pc_next    = j + 1'b1;
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end else begin
              j_next = j + 1'b1;
            end
          end

          default: begin
            // Forward bracket scan; an unmatched bracket ends the program.
            if (ins_class.is_open) begin
              depth_new = depth + 1'b1;
            end else if (ins_class.is_close) begin
              depth_new = depth - 1'b1;
            end
            if (j >= len) begin
              pc_next    = len;
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end else if (depth_new == '0) begin
              pc_next    = j + 1'b1;
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end else begin
              depth_next = depth_new;
              j_next     = j + 1'b1;
            end
          end
        endcase
      end

      ST_CLEAR: begin
        // The sweep after reset gives no result; the one after a restart does.
        if (tape_status.clear_last) begin
          state_next       = ST_IDLE;
          done_next        = clear_reply;
          clear_reply_next = 1'b0;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    result_next.out_valid       = emit;
    result_next.out_byte        = emit ? cell_q : 8'd0;
    result_next.error           = err_next;
    result_next.halted          = err_next || (pc_next >= len);
    result_next.program_counter = pc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      scan_mode     <= SCAN_FWD_BRACKET;
      pc            <= '0;
      cp            <= '0;
      tsize         <= RESET_TAPE_SIZE;
      err           <= 1'b0;
      clear_reply   <= 1'b0;
      done          <= 1'b0;
      init_size_cfg <= ebf_pkg::INIT_TAPE_SIZE_RESET;
      prog_len_cfg  <= ebf_pkg::PROG_LENGTH_RESET;
    end else begin
      state       <= state_next;
      scan_mode   <= scan_mode_next;
      pc          <= pc_next;
      cp          <= cp_next;
      tsize       <= tsize_next;
      err         <= err_next;
      clear_reply <= clear_reply_next;
      done        <= done_next;
      if (cfg_valid) begin
        case (cfg_index)
          ebf_pkg::CFG_INITIAL_TAPE_SIZE: init_size_cfg <= cfg_data;
          ebf_pkg::CFG_PROGRAM_LENGTH:    prog_len_cfg  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: the request is held for EXEC, the result for its strobe.
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    j      <= j_next;
    depth  <= depth_next;
    result <= result_next;
  end

  // An accepted request always moves the controller into EXEC.
  `EBF_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == ST_EXEC)
  // Results are only shown while the controller is free for the next request.
  `EBF_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  // An error always reports the machine as halted.
  `EBF_ASSERT_IMPL(a_error_halts, clk, rst, done && result.error, result.halted)
  // The tape sweep only runs while the controller waits for it.
  `EBF_ASSERT_IMPL(a_clear_state, clk, rst, tape_status.clearing, state == ST_CLEAR)

endmodule

@@ design/ebf_prog_store.sv @@
module ebf_prog_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [11:0]          wr_addr,
  input  logic [7:0]           wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [7:0]           rd_data,
  output ebf_pkg::prog_class_t rd_class
);

  logic [7:0]  mem [DEPTH];
  logic [31:0] wr_addr_w;
  logic        wr_in_range;

  // Loads beyond the end of the store are dropped.
  assign wr_addr_w   = 32'(wr_addr);
  assign wr_in_range = wr_addr_w < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr_w[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_class.is_open  = (rd_data == ebf_pkg::CH_LBRACKET);
    rd_class.is_close = (rd_data == ebf_pkg::CH_RBRACKET);
    rd_class.is_hash  = (rd_data == ebf_pkg::CH_HASH);
  end

endmodule

@@ design/ebf_tape.sv @@
module ebf_tape #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int SW    = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ebf_pkg::tape_cmd_t    cmd,
  input  logic [AW-1:0]         wr_addr,
  input  logic [AW-1:0]         rd_addr,
  input  logic [SW-1:0]         clear_limit,
  output logic [7:0]            rd_data,
  output ebf_pkg::tape_status_t status
);

  logic [7:0]    mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] cnt;
  logic [SW-1:0] limit;
  logic          last;

  // The sweep zeroes cells 0 to limit-1, one per cycle.
  assign last = clearing && ((SW'(cnt) + SW'(1)) == limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      cnt      <= '0;
      limit    <= SW'(DEPTH);
    end else if (cmd.clear) begin
      clearing <= 1'b1;
      cnt      <= '0;
      limit    <= clear_limit;
    end else if (clearing) begin
      if (last) begin
        clearing <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[cnt] <= 8'd0;
    end else if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    status.clearing   = clearing;
    status.clear_last = last;
  end

endmodule
